// ===== rtl/rcf_pkg.sv =====
// Shared types and constants for the request command framer.
// Used by rcf_parser, rcf_out_stage and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rcf_pkg;

    // Largest argument count the framer ever accepts
    localparam int unsigned ARG_LIMIT = 32;

    // Protocol characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Reset value of the argument cap register
    localparam logic [5:0] ARG_CAP_RESET = 6'd32;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } rcf_kind_t;

    // Error codes
    localparam logic [2:0] ERR_NO_STAR  = 3'd0;
    localparam logic [2:0] ERR_BAD_CNT  = 3'd1;
    localparam logic [2:0] ERR_NO_DOLL  = 3'd2;
    localparam logic [2:0] ERR_NEG_LEN  = 3'd3;
    localparam logic [2:0] ERR_BIG_LEN  = 3'd4;

    // Parser phases
    typedef enum logic [2:0] {
        PH_STAR   = 3'd0,
        PH_HDR    = 3'd1,
        PH_DOLLAR = 3'd2,
        PH_LEN    = 3'd3,
        PH_DATA   = 3'd4,
        PH_TRAIL  = 3'd5,
        PH_STUCK  = 3'd6
    } rcf_phase_t;

    // One result item
    typedef struct packed {
        rcf_kind_t  kind;
        logic [7:0] data_byte;
        logic [4:0] arg_index;
        logic       arg_last;
        logic [5:0] arg_count;
        logic [2:0] error_code;
    } rcf_result_t;

endpackage

`default_nettype wire

// ===== rtl/rcf_in_stage.sv =====
// Input register of the request command framer: holds one received byte.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module rcf_in_stage
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_in,
    input  wire logic       take,
    output logic            item_valid,
    output logic [7:0]      item_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // Slot is free when empty or drained in this cycle
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rcf_parser.sv =====
// Framing state machine: number-line parsing, argument tracking, results.
// Depends on rcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcf_parser
#(
    parameter int unsigned LEN_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [5:0]        arg_cap,
    input  wire logic [7:0]        item_byte,
    input  wire logic              take,
    output logic                   res_valid,
    output rcf_pkg::rcf_result_t   res
);

    import rcf_pkg::*;

    localparam int unsigned ACC_W = LEN_BITS + 1;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] ACC_SAT = ACC_MAX / 10;

    rcf_phase_t         phase_reg, phase_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;
    logic               cr_reg, cr_next;
    logic               started_reg, started_next;
    logic [5:0]         total_reg, total_next;
    logic [4:0]         cur_reg, cur_next;
    logic [LEN_BITS-1:0] left_reg, left_next;
    logic [1:0]         trail_reg, trail_next;

    // Shared decode of the current byte and state
    logic               line_end;
    logic               is_space;
    logic               is_digit;
    logic [ACC_W+3:0]   acc_mul;
    logic [ACC_W+3:0]   acc_sum;
    logic [ACC_W-1:0]   feed_acc;
    logic               feed_neg;
    logic               feed_done;
    logic               feed_started;
    logic [5:0]         lim;
    logic               hdr_bad;
    logic               len_neg;
    logic               len_big;
    logic               len_zero;
    logic               data_last;
    logic               trail_end;
    logic [5:0]         next_arg;
    logic               cmd_end;

    assign line_end = cr_reg && (item_byte == CH_LF);
    assign is_space = (item_byte == CH_SPACE) || (item_byte == CH_TAB) ||
                      (item_byte == CH_LF) || (item_byte == CH_VT) ||
                      (item_byte == CH_FF) || (item_byte == CH_CR);
    assign is_digit = (item_byte >= CH_ZERO) && (item_byte <= CH_NINE);
    assign acc_mul  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
    assign acc_sum  = acc_mul + {{ACC_W{1'b0}}, item_byte[3:0]};

    // atoi-style digit accumulation with saturation
    always_comb
    begin
        feed_acc     = acc_reg;
        feed_neg     = neg_reg;
        feed_done    = done_reg;
        feed_started = started_reg;
        if (!done_reg && !(!started_reg && is_space))
        begin
            feed_started = 1'b1;
            if (!started_reg && item_byte == CH_MINUS)
            begin
                feed_neg = 1'b1;
            end
            else if (!started_reg && item_byte == CH_PLUS)
            begin
                feed_neg = neg_reg;
            end
            else if (is_digit)
            begin
                if (acc_reg > ACC_SAT || acc_sum > {4'b0000, ACC_MAX})
                begin
                    feed_acc = ACC_MAX;
                end
                else
                begin
                    feed_acc = acc_sum[ACC_W-1:0];
                end
            end
            else
            begin
                feed_done = 1'b1;
            end
        end
    end

    // Line checks and argument bookkeeping
    assign lim       = (arg_cap < 6'(ARG_LIMIT)) ? arg_cap : 6'(ARG_LIMIT);
    assign hdr_bad   = neg_reg || (acc_reg == '0) ||
                       (acc_reg > {{(ACC_W-6){1'b0}}, lim});
    assign len_neg   = neg_reg && (acc_reg != '0);
    assign len_big   = acc_reg[ACC_W-1];
    assign len_zero  = (acc_reg == '0);
    assign data_last = (left_reg <= {{(LEN_BITS-1){1'b0}}, 1'b1});
    assign trail_end = (trail_reg <= 2'd1);
    assign next_arg  = {1'b0, cur_reg} + 6'd1;
    assign cmd_end   = (next_arg >= total_reg);

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        done_next    = done_reg;
        cr_next      = cr_reg;
        started_next = started_reg;
        total_next   = total_reg;
        cur_next     = cur_reg;
        left_next    = left_reg;
        trail_next   = trail_reg;
        unique case (phase_reg)
            PH_STAR, PH_DOLLAR:
            begin
                if ((phase_reg == PH_STAR && item_byte != CH_STAR) ||
                    (phase_reg == PH_DOLLAR && item_byte != CH_DOLLAR))
                begin
                    phase_next = PH_STUCK;
                end
                else
                begin
                    acc_next     = '0;
                    neg_next     = 1'b0;
                    done_next    = 1'b0;
                    cr_next      = 1'b0;
                    started_next = 1'b0;
                    phase_next   = (phase_reg == PH_STAR) ? PH_HDR : PH_LEN;
                end
            end
            PH_HDR:
            begin
                if (!line_end)
                begin
                    acc_next     = feed_acc;
                    neg_next     = feed_neg;
                    done_next    = feed_done;
                    started_next = feed_started;
                    cr_next      = (item_byte == CH_CR);
                end
                else if (hdr_bad)
                begin
                    phase_next = PH_STUCK;
                end
                else
                begin
                    total_next = acc_reg[5:0];
                    cur_next   = '0;
                    phase_next = PH_DOLLAR;
                end
            end
            PH_LEN:
            begin
                if (!line_end)
                begin
                    acc_next     = feed_acc;
                    neg_next     = feed_neg;
                    done_next    = feed_done;
                    started_next = feed_started;
                    cr_next      = (item_byte == CH_CR);
                end
                else if (len_neg || len_big)
                begin
                    phase_next = PH_STUCK;
                end
                else if (len_zero)
                begin
                    left_next  = '0;
                    trail_next = 2'd2;
                    phase_next = PH_TRAIL;
                end
                else
                begin
                    left_next  = acc_reg[LEN_BITS-1:0];
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (data_last)
                begin
                    left_next  = '0;
                    trail_next = 2'd2;
                    phase_next = PH_TRAIL;
                end
                else
                begin
                    left_next = left_reg - {{(LEN_BITS-1){1'b0}}, 1'b1};
                end
            end
            PH_TRAIL:
            begin
                if (!trail_end)
                begin
                    trail_next = trail_reg - 2'd1;
                end
                else
                begin
                    trail_next = '0;
                    if (cmd_end)
                    begin
                        cur_next   = '0;
                        phase_next = PH_STAR;
                    end
                    else
                    begin
                        cur_next   = next_arg[4:0];
                        phase_next = PH_DOLLAR;
                    end
                end
            end
            default:
            begin
                phase_next = PH_STUCK;
            end
        endcase
    end

    // Result for the current byte
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        unique case (phase_reg)
            PH_STAR:
            begin
                if (item_byte != CH_STAR)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_NO_STAR;
                end
            end
            PH_DOLLAR:
            begin
                if (item_byte != CH_DOLLAR)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_NO_DOLL;
                end
            end
            PH_HDR:
            begin
                if (line_end && hdr_bad)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_BAD_CNT;
                end
            end
            PH_LEN:
            begin
                if (line_end)
                begin
                    res_valid = 1'b1;
                    if (len_neg)
                    begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_NEG_LEN;
                    end
                    else if (len_big)
                    begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_BIG_LEN;
                    end
                    else if (len_zero)
                    begin
                        res.kind      = KIND_EMPTY;
                        res.arg_index = cur_reg;
                    end
                    else
                    begin
                        res_valid = 1'b0;
                    end
                end
            end
            PH_DATA:
            begin
                res_valid     = 1'b1;
                res.kind      = KIND_DATA;
                res.data_byte = item_byte;
                res.arg_index = cur_reg;
                res.arg_last  = data_last;
            end
            PH_TRAIL:
            begin
                if (trail_end && cmd_end)
                begin
                    res_valid     = 1'b1;
                    res.kind      = KIND_DONE;
                    res.arg_count = total_reg;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // State registers, advanced once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_STAR;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            done_reg    <= 1'b0;
            cr_reg      <= 1'b0;
            started_reg <= 1'b0;
            total_reg   <= '0;
            cur_reg     <= '0;
            left_reg    <= '0;
            trail_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            done_reg    <= done_next;
            cr_reg      <= cr_next;
            started_reg <= started_next;
            total_reg   <= total_next;
            cur_reg     <= cur_next;
            left_reg    <= left_next;
            trail_reg   <= trail_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rcf_out_stage.sv =====
// Result register of the request command framer.
// Depends on rcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcf_out_stage
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire rcf_pkg::rcf_result_t res,
    output logic                      out_free,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rcf_pkg::rcf_result_t      out_res
);

    import rcf_pkg::*;

    logic        valid_reg;
    rcf_result_t res_reg;

    // Register can take a new result when empty or being drained
    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= load;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/resp_command_framer_top.sv =====
// Top level of the request command framer: config register and stage wiring.
// Depends on rcf_pkg, rcf_in_stage, rcf_parser and rcf_out_stage.
//
// Usage:
//   Input channel in_valid/in_ready/byte_in carries one request byte per
//   transfer. Output channel out_valid/out_ready carries one result per
//   transfer: kind, data_byte, arg_index, arg_last, arg_count, error_code.
//   Config channel cfg_valid/cfg_ready/cfg_data writes the argument cap;
//   cfg_ready is always high, and writes are meant for idle periods only.
//   A byte accepted into the input register is parsed by the combinational
//   parser step; its result, if any, goes into the result register when the
//   byte is consumed, which waits while the result register is full and the
//   receiver stalls. Throughput is one byte per clock while no result waits,
//   set by the parser between the input register and the result register.
//   Reset clears the parser to wait for a '*' header, empties both
//   registers and sets the argument cap to 32. When the receiver stalls with
//   a result pending, bytes that give no result keep flowing; the next byte
//   that gives a result waits in the input register, and in_ready drops.
//   After a protocol error the block gives no further results until reset.
`timescale 1ns / 1ps
`default_nettype none

module resp_command_framer_top
#(
    parameter int unsigned LEN_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      data_byte,
    output logic [4:0]      arg_index,
    output logic            arg_last,
    output logic [5:0]      arg_count,
    output logic [2:0]      error_code,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [5:0] cfg_data
);

    import rcf_pkg::*;

    logic [5:0]  arg_cap_reg;
    logic        item_valid;
    logic [7:0]  item_byte;
    logic        take;
    logic        load;
    logic        res_valid;
    logic        out_free;
    rcf_result_t res;
    rcf_result_t out_res;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_cap_reg <= ARG_CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            arg_cap_reg <= cfg_data;
        end
    end

    // Consume a byte unless its result has nowhere to go
    assign take = item_valid && (!res_valid || out_free);
    assign load = take && res_valid;

    rcf_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    rcf_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_cap   (arg_cap_reg),
        .item_byte (item_byte),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    rcf_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // Result fields
    assign kind       = out_res.kind;
    assign data_byte  = out_res.data_byte;
    assign arg_index  = out_res.arg_index;
    assign arg_last   = out_res.arg_last;
    assign arg_count  = out_res.arg_count;
    assign error_code = out_res.error_code;

endmodule

`default_nettype wire

// ===== dv/rcf_result_checker.sv =====
// Scoreboard for the request command framer: tracks every transfer on the
// input, config and result channels, predicts results and compares them.
// Depends on rcf_pkg.
`timescale 1ns / 1ps

module rcf_result_checker
#(
    parameter int unsigned LEN_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        byte_in,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [1:0]        kind,
    input  logic [7:0]        data_byte,
    input  logic [4:0]        arg_index,
    input  logic              arg_last,
    input  logic [5:0]        arg_count,
    input  logic [2:0]        error_code,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [5:0]        cfg_data,
    output int unsigned       mismatch_count,
    output int unsigned       results_owed
);

    import rcf_pkg::*;

    localparam int unsigned ACC_MAX = (1 << (LEN_BITS + 1)) - 1;
    localparam int unsigned LEN_MAX = (1 << LEN_BITS) - 1;

    // Shadow copy of the framer state
    rcf_phase_t            ph;
    logic [LEN_BITS:0]     num_acc;
    bit                    num_neg;
    bit                    digits_done;
    bit                    cr_seen;
    bit                    num_started;
    logic [5:0]            args_total;
    logic [4:0]            cur_arg;
    logic [LEN_BITS-1:0]   bytes_left;
    logic [1:0]            trailer_left;
    logic [5:0]            arg_cap_copy;

    rcf_result_t           frame_results_q[$];
    int unsigned           bad_results;

    task automatic clear_number();
        num_acc     = '0;
        num_neg     = 1'b0;
        digits_done = 1'b0;
        cr_seen     = 1'b0;
        num_started = 1'b0;
    endtask

    task automatic push_result(input rcf_kind_t k, input logic [7:0] d, input logic [4:0] idx,
                               input logic lst, input logic [5:0] cnt, input logic [2:0] err);
        rcf_result_t r;
        r.kind       = k;
        r.data_byte  = d;
        r.arg_index  = idx;
        r.arg_last   = lst;
        r.arg_count  = cnt;
        r.error_code = err;
        frame_results_q.push_back(r);
    endtask

    task automatic raise_error(input logic [2:0] err);
        ph = PH_STUCK;
        push_result(KIND_ERROR, 8'h00, 5'd0, 1'b0, 6'd0, err);
    endtask

    // atoi-style digit accumulation with saturation
    task automatic feed_number(input logic [7:0] b);
        int unsigned grown;
        bit skip;
        skip = 1'b0;
        if (digits_done)
            skip = 1'b1;
        else if (!num_started)
        begin
            if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF
                || b == CH_CR)
                skip = 1'b1;
            else
            begin
                num_started = 1'b1;
                if (b == CH_MINUS)
                begin
                    num_neg = 1'b1;
                    skip    = 1'b1;
                end
                else if (b == CH_PLUS)
                    skip = 1'b1;
            end
        end
        if (!skip)
        begin
            if (b >= CH_ZERO && b <= CH_NINE)
            begin
                grown = 32'(num_acc) * 10 + 32'(b - CH_ZERO);
                if (32'(num_acc) > ACC_MAX / 10 || grown > ACC_MAX)
                    num_acc = '1;
                else
                    num_acc = grown[LEN_BITS:0];
            end
            else
                digits_done = 1'b1;
        end
    endtask

    // A number line ends on the first CR LF pair
    task automatic feed_line(input logic [7:0] b, output bit ended);
        ended = 1'b0;
        if (cr_seen && b == CH_LF)
            ended = 1'b1;
        else
        begin
            feed_number(b);
            cr_seen = (b == CH_CR);
        end
    endtask

    // One byte through the framer
    task automatic frame_byte(input logic [7:0] b);
        bit          ended;
        int unsigned lim;
        logic [5:0]  next_arg;
        case (ph)
            PH_STAR:
                if (b != CH_STAR)
                    raise_error(ERR_NO_STAR);
                else
                begin
                    clear_number();
                    ph = PH_HDR;
                end
            PH_HDR:
            begin
                lim = (arg_cap_copy < ARG_LIMIT) ? arg_cap_copy : ARG_LIMIT;
                feed_line(b, ended);
                if (ended)
                begin
                    if (num_neg || num_acc == 0 || num_acc > lim)
                        raise_error(ERR_BAD_CNT);
                    else
                    begin
                        args_total = num_acc[5:0];
                        cur_arg    = '0;
                        ph         = PH_DOLLAR;
                    end
                end
            end
            PH_DOLLAR:
                if (b != CH_DOLLAR)
                    raise_error(ERR_NO_DOLL);
                else
                begin
                    clear_number();
                    ph = PH_LEN;
                end
            PH_LEN:
            begin
                feed_line(b, ended);
                if (ended)
                begin
                    if (num_neg && num_acc != 0)
                        raise_error(ERR_NEG_LEN);
                    else if (num_acc > LEN_MAX)
                        raise_error(ERR_BIG_LEN);
                    else
                    begin
                        bytes_left = num_acc[LEN_BITS-1:0];
                        if (bytes_left == 0)
                        begin
                            trailer_left = 2'd2;
                            ph           = PH_TRAIL;
                            push_result(KIND_EMPTY, 8'h00, cur_arg, 1'b0, 6'd0, 3'd0);
                        end
                        else
                            ph = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                push_result(KIND_DATA, b, cur_arg, bytes_left <= 1, 6'd0, 3'd0);
                if (bytes_left <= 1)
                begin
                    bytes_left   = '0;
                    trailer_left = 2'd2;
                    ph           = PH_TRAIL;
                end
                else
                    bytes_left = bytes_left - LEN_BITS'(1);
            end
            PH_TRAIL:
                if (trailer_left > 1)
                    trailer_left = trailer_left - 2'd1;
                else
                begin
                    trailer_left = '0;
                    next_arg     = {1'b0, cur_arg} + 6'd1;
                    if (next_arg >= args_total)
                    begin
                        ph      = PH_STAR;
                        cur_arg = '0;
                        push_result(KIND_DONE, 8'h00, 5'd0, 1'b0, args_total, 3'd0);
                    end
                    else
                    begin
                        cur_arg = next_arg[4:0];
                        ph      = PH_DOLLAR;
                    end
                end
            default:
                ph = PH_STUCK;
        endcase
    endtask

    task automatic note_mismatch(input string field, input int unsigned want,
                                 input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        bad_results++;
    endtask

    // Compare results, then track config and input transfers
    always @(posedge clk or negedge rst_n)
    begin
        rcf_result_t want;
        if (!rst_n)
        begin
            ph            = PH_STAR;
            clear_number();
            args_total    = '0;
            cur_arg       = '0;
            bytes_left    = '0;
            trailer_left  = '0;
            arg_cap_copy  = ARG_CAP_RESET;
            frame_results_q.delete();
            bad_results   = 0;
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_results_q.size() == 0)
                begin
                    $display("%0t: result with none expected, kind %0d data %0d index %0d",
                             $time, kind, data_byte, arg_index);
                    bad_results++;
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    if (kind !== want.kind)
                        note_mismatch("kind", want.kind, 8'(kind));
                    if (data_byte !== want.data_byte)
                        note_mismatch("data_byte", want.data_byte, data_byte);
                    if (arg_index !== want.arg_index)
                        note_mismatch("arg_index", want.arg_index, 8'(arg_index));
                    if (arg_last !== want.arg_last)
                        note_mismatch("arg_last", want.arg_last, 8'(arg_last));
                    if (arg_count !== want.arg_count)
                        note_mismatch("arg_count", want.arg_count, 8'(arg_count));
                    if (error_code !== want.error_code)
                        note_mismatch("error_code", want.error_code, 8'(error_code));
                end
            end
            if (cfg_valid && cfg_ready)
                arg_cap_copy = cfg_data;
            if (in_valid && in_ready)
                frame_byte(byte_in);
            mismatch_count <= bad_results;
            results_owed   <= frame_results_q.size();
        end
    end

endmodule

// ===== dv/tb_resp_command_framer_top.sv =====
// Testbench top for the request command framer: clock, reset, byte stream
// stimulus, receiver stalls, config writes, watchdog and verdict.
// Depends on rcf_pkg, resp_command_framer_top and rcf_result_checker.
`timescale 1ns / 1ps

module tb_resp_command_framer_top;

    import rcf_pkg::*;

    localparam int unsigned LEN_BITS   = 16;
    localparam int unsigned IDLE_LIMIT = 3000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  byte_in   = 8'h00;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [5:0]  cfg_data  = 6'd0;

    wire logic       in_ready;
    wire logic       out_valid;
    wire logic [1:0] kind;
    wire logic [7:0] data_byte;
    wire logic [4:0] arg_index;
    wire logic       arg_last;
    wire logic [5:0] arg_count;
    wire logic [2:0] error_code;
    wire logic       cfg_ready;

    int unsigned mismatch_count;
    int unsigned results_owed;

    logic [7:0]  stream_q[$];
    int unsigned burst_left = 0;
    int unsigned fed_total  = 0;

    resp_command_framer_top #(.LEN_BITS(LEN_BITS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .data_byte  (data_byte),
        .arg_index  (arg_index),
        .arg_last   (arg_last),
        .arg_count  (arg_count),
        .error_code (error_code),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    rcf_result_checker #(.LEN_BITS(LEN_BITS)) result_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_in        (byte_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .data_byte      (data_byte),
        .arg_index      (arg_index),
        .arg_last       (arg_last),
        .arg_count      (arg_count),
        .error_code     (error_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: switches between free-running, light, heavy and periodic stalls
    int unsigned stall_mode = 0;
    int unsigned mode_left  = 0;
    logic [3:0]  beat       = 4'd0;

    always @(posedge clk)
    begin
        beat <= beat + 4'd1;
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(30, 400);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (beat >= 4'd6);
        endcase
    end

    // Watchdog: too long without any transfer ends the run
    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("tb_resp_command_framer_top: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One byte transfer, with random gaps between bursts
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        fed_total++;
    endtask

    task automatic flush_stream();
        while (stream_q.size() != 0)
            send_byte(stream_q.pop_front());
    endtask

    // Hold off until every predicted result has come out, plus settling time
    task automatic wait_results_done();
        in_valid   <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_arg_cap(input logic [5:0] value);
        wait_results_done();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_decimal(input int unsigned value);
        logic [7:0] digs[$];
        do
        begin
            digs.push_front(8'(CH_ZERO + value % 10));
            value = value / 10;
        end
        while (value != 0);
        foreach (digs[i])
            stream_q.push_back(digs[i]);
    endtask

    // Number line; when not plain, adds whitespace, sign, leading zeros and junk
    task automatic add_number_line(input int unsigned value, input bit len_line, input bit plain);
        logic [7:0] ws;
        logic [7:0] prev;
        logic [7:0] jb;
        bit         no_digits;
        prev = 8'h00;
        if (plain || $urandom_range(0, 2) != 0)
            add_decimal(value);
        else
        begin
            repeat ($urandom_range(0, 3))
            begin
                case ($urandom_range(0, 5))
                    0:       ws = CH_SPACE;
                    1:       ws = CH_TAB;
                    2:       ws = CH_LF;
                    3:       ws = CH_VT;
                    4:       ws = CH_FF;
                    default: ws = CH_CR;
                endcase
                // CR LF here would close the line early
                if (prev == CH_CR && ws == CH_LF)
                    ws = CH_SPACE;
                stream_q.push_back(ws);
                prev = ws;
            end
            case ($urandom_range(0, 3))
                0:       stream_q.push_back(CH_PLUS);
                1:       if (len_line && value == 0) stream_q.push_back(CH_MINUS);
                default: ;
            endcase
            no_digits = (value == 0 && $urandom_range(0, 2) == 0);
            if (!no_digits)
            begin
                repeat ($urandom_range(0, 2)) stream_q.push_back(CH_ZERO);
                add_decimal(value);
                if ($urandom_range(0, 1) != 0)
                begin
                    // trailing junk starts with a non-digit and never forms CR LF
                    do
                        jb = 8'($urandom_range(0, 255));
                    while ((jb >= CH_ZERO && jb <= CH_NINE) || jb == CH_CR);
                    stream_q.push_back(jb);
                    repeat ($urandom_range(0, 3))
                    begin
                        jb = 8'($urandom_range(0, 255));
                        stream_q.push_back(jb);
                        if (jb == CH_CR)
                            stream_q.push_back(CH_SPACE);
                    end
                end
            end
        end
        stream_q.push_back(CH_CR);
        stream_q.push_back(CH_LF);
    endtask

    task automatic add_header(input int unsigned count, input bit plain);
        stream_q.push_back(CH_STAR);
        add_number_line(count, 1'b0, plain);
    endtask

    // Length line, random data and two unchecked trailer bytes
    task automatic add_argument(input int unsigned len, input bit plain);
        stream_q.push_back(CH_DOLLAR);
        add_number_line(len, 1'b1, plain);
        repeat (len) stream_q.push_back(8'($urandom_range(0, 255)));
        repeat (2) stream_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Mostly short arguments, now and then a few hundred bytes
    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 4);
        else if (r < 19)
            return $urandom_range(5, 24);
        else
            return $urandom_range(100, 300);
    endfunction

    task automatic run_random_phase(input logic [5:0] max_setting, input int unsigned quota);
        int unsigned lim;
        int unsigned stop_at;
        int unsigned count;
        write_arg_cap(max_setting);
        lim     = (max_setting < ARG_LIMIT) ? max_setting : ARG_LIMIT;
        stop_at = fed_total + quota;
        // widest command first so the top index and count are hit
        if (lim == ARG_LIMIT)
        begin
            add_header(lim, 1'b0);
            repeat (lim) add_argument($urandom_range(0, 1), 1'b0);
            flush_stream();
        end
        while (fed_total < stop_at)
        begin
            if ($urandom_range(0, 9) < 6)
                count = $urandom_range(1, (lim < 4) ? lim : 4);
            else
                count = $urandom_range(1, lim);
            add_header(count, 1'b0);
            repeat (count) add_argument(pick_length(), 1'b0);
            flush_stream();
            if ($urandom_range(0, 9) == 0)
                wait_results_done();
        end
    endtask

    // The block locks up after an error, so exactly one error ends the run
    task automatic run_error_tail();
        logic [2:0]  err;
        logic [7:0]  jb;
        int unsigned m;
        err = 3'($urandom_range(0, 4));
        case (err)
            ERR_NO_STAR:
            begin
                do
                    jb = 8'($urandom_range(0, 255));
                while (jb == CH_STAR);
                stream_q.push_back(jb);
            end
            ERR_BAD_CNT:
                case ($urandom_range(0, 4))
                    0: add_header(0, 1'b0);
                    1:
                    begin
                        stream_q.push_back(CH_STAR);
                        stream_q.push_back(CH_MINUS);
                        add_number_line($urandom_range(1, 32), 1'b0, 1'b1);
                    end
                    2:
                    begin
                        write_arg_cap(6'd0);
                        add_header(1, 1'b1);
                    end
                    3:
                    begin
                        m = $urandom_range(1, 31);
                        write_arg_cap(6'(m));
                        add_header(m + 1, 1'b0);
                    end
                    default:
                    begin
                        write_arg_cap(6'd63);
                        add_header($urandom_range(0, 1) ? 33 : 9999999, 1'b0);
                    end
                endcase
            ERR_NO_DOLL:
            begin
                add_header(2, 1'b0);
                add_argument(pick_length(), 1'b0);
                do
                    jb = 8'($urandom_range(0, 255));
                while (jb == CH_DOLLAR);
                stream_q.push_back(jb);
            end
            ERR_NEG_LEN:
            begin
                add_header(1, 1'b0);
                stream_q.push_back(CH_DOLLAR);
                stream_q.push_back(CH_MINUS);
                add_number_line($urandom_range(1, 70000), 1'b1, 1'b1);
            end
            default:
            begin
                add_header(1, 1'b0);
                stream_q.push_back(CH_DOLLAR);
                add_number_line($urandom_range(0, 1) ? 65536 : $urandom_range(65537, 999999),
                                1'b1, 1'b0);
            end
        endcase
        // bytes after the error must give nothing
        repeat ($urandom_range(10, 30)) stream_q.push_back(8'($urandom_range(0, 255)));
        flush_stream();
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty argument, then data bytes 0x00 and 0xFF, one argument max
        write_arg_cap(6'd1);
        add_header(1, 1'b1);
        add_argument(0, 1'b1);
        add_header(1, 1'b1);
        stream_q.push_back(CH_DOLLAR);
        add_number_line(2, 1'b1, 1'b1);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        stream_q.push_back(CH_STAR);
        stream_q.push_back(CH_DOLLAR);
        flush_stream();

        // Random commands across register settings
        run_random_phase(6'd32, 200);
        run_random_phase(6'd63, 200);
        run_random_phase(6'($urandom_range(2, 31)), 200);
        run_random_phase(6'd1, 200);
        run_random_phase(6'd32, 200);

        run_error_tail();

        wait_results_done();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("tb_resp_command_framer_top: PASS");
        else
            $display("tb_resp_command_framer_top: FAIL");
        $finish;
    end

endmodule
